// ===== rtl/pfbhex_pkg.sv =====
// ----------------------------------------------------------------------------
// pfbhex_pkg
// Shared types and constants of the binary-font to hex-text converter.
// ----------------------------------------------------------------------------
package pfbhex_pkg;

	localparam int MAX_RES     = 5;
	localparam int RES_CNT_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam logic [7:0] LINE_CHARS = 8'd78;

	localparam logic [7:0] MARKER     = 8'h80;
	localparam logic [7:0] MARKER_INV = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	localparam logic [7:0] TYPE_TEXT = 8'd1;
	localparam logic [7:0] TYPE_BIN  = 8'd2;
	localparam logic [7:0] TYPE_END  = 8'd3;

	localparam logic [2:0] ST_END_SEGMENT  = 3'd0;
	localparam logic [2:0] ST_PASS_OK      = 3'd1;
	localparam logic [2:0] ST_NO_HEADER    = 3'd2;
	localparam logic [2:0] ST_BAD_MARKER   = 3'd3;
	localparam logic [2:0] ST_BAD_TYPE     = 3'd4;
	localparam logic [2:0] ST_SHORT_HEADER = 3'd5;
	localparam logic [2:0] ST_TRUNCATED    = 3'd6;

	typedef enum logic [2:0] {
		PH_START,
		PH_SECOND,
		PH_PASS,
		PH_HEADER,
		PH_TEXT,
		PH_BINARY,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic [2:0] status;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0]   items;
		logic [RES_CNT_W-1:0] count;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'd0, d};
		end else begin
			c = 8'h41 + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== rtl/pfb_segments_to_hex_text_unit.sv =====
// ----------------------------------------------------------------------------
// pfb_segments_to_hex_text_unit
// Converts a binary Type 1 font byte stream into hex text, one character
// per output transfer, with a final status item.
//
//   channel  dir  tdata                          tuser      tlast
//   s_*      in   [7:0] in_byte                  -          end_of_file
//   m_*      out  [7:0] out_byte, [10:8] status  is_status  last_of_run
//   cfg_*    in   cfg_wdata = inverted_header_mode (write on cfg_wen)
//
// One input transfer per cycle while the command queue has room; each byte
// turns into zero to five output transfers, one per cycle while m_tready
// is high, set by the output serializer (a binary byte gives two to five
// transfers, a text byte one or two).
// Reset clears parser state, queue and output register; the header mode
// resets to 0. Output stalls fill the four-entry queue before s_tready drops.
// ----------------------------------------------------------------------------
module pfb_segments_to_hex_text_unit #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
	output logic        m_tuser,   // [0] is_status
	output logic        m_tlast
);

	logic             q_full;
	logic             q_push;
	pfbhex_pkg::cmd_t q_cmd;
	logic             q_pop;
	logic             head_valid;
	pfbhex_pkg::cmd_t head_cmd;
	pfbhex_pkg::res_t out_res;

	pfbhex_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.end_of_file (s_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	pfbhex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	pfbhex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res),
		.out_last   (m_tlast)
	);

	assign m_tdata = {5'd0, out_res.status, out_res.out_byte};
	assign m_tuser = out_res.is_status;

endmodule

// ===== rtl/pfbhex_front.sv =====
// ----------------------------------------------------------------------------
// pfbhex_front
// Parses the input byte stream and turns each byte into a command of up to
// five result items for the back end.
// ----------------------------------------------------------------------------
module pfbhex_front #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                end_of_file,
	input  logic                q_full,
	output logic                q_push,
	output pfbhex_pkg::cmd_t    q_cmd
);

	localparam logic [31:0] LEN_LIM = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	typedef struct packed {
		pfbhex_pkg::phase_t     phase;
		logic [7:0]             held;
		logic [2:0]             hcnt;
		logic                   seg_bin;
		logic [31:0]            len_shift;
		logic [LENGTH_BITS-1:0] remaining;
		logic [7:0]             line_pos;
	} st_t;

	typedef struct packed {
		st_t              st;
		pfbhex_pkg::cmd_t cmd;
	} ctx_t;

	st_t  st_q;
	logic mode_q;
	ctx_t nxt;
	logic accept;

	function automatic ctx_t emit(input ctx_t c, input logic [7:0] ch, input logic is_s,
			input logic [2:0] code);
		ctx_t r;
		r = c;
		if (r.cmd.count < pfbhex_pkg::RES_CNT_W'(pfbhex_pkg::MAX_RES)) begin
			r.cmd.items[r.cmd.count].out_byte  = ch;
			r.cmd.items[r.cmd.count].is_status = is_s;
			r.cmd.items[r.cmd.count].status    = code;
			r.cmd.count = r.cmd.count + 3'd1;
		end
		return r;
	endfunction

	function automatic ctx_t finish(input ctx_t c, input logic [2:0] code);
		ctx_t r;
		r = emit(c, 8'h00, 1'b1, code);
		r.st.phase = pfbhex_pkg::PH_DONE;
		return r;
	endfunction

	function automatic ctx_t segment_end(input ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.seg_bin && r.st.line_pos != 8'd0) begin
			r = emit(r, pfbhex_pkg::CH_LF, 1'b0, pfbhex_pkg::ST_END_SEGMENT);
			r.st.line_pos = 8'd0;
		end
		r.st.phase = pfbhex_pkg::PH_HEADER;
		r.st.hcnt  = 3'd0;
		return r;
	endfunction

	function automatic ctx_t after_payload(input ctx_t c, input logic eof);
		ctx_t r;
		r = c;
		if (r.st.remaining == '0) begin
			r = segment_end(r);
			if (eof) r = finish(r, pfbhex_pkg::ST_NO_HEADER);
		end else if (eof) begin
			r = segment_end(r);
			r = finish(r, pfbhex_pkg::ST_TRUNCATED);
		end
		return r;
	endfunction

	function automatic ctx_t header_byte(input ctx_t c, input logic [7:0] b, input logic eof,
			input logic mode);
		ctx_t        r;
		logic [7:0]  v;
		logic [1:0]  k;
		logic [31:0] lsh;
		r   = c;
		v   = mode ? ~b : b;
		k   = 2'(r.st.hcnt - 3'd2);
		lsh = r.st.len_shift;
		case (r.st.hcnt) inside
			3'd0: begin
				if (eof) begin
					r = finish(r, pfbhex_pkg::ST_NO_HEADER);
				end else if (b != (mode ? pfbhex_pkg::MARKER_INV : pfbhex_pkg::MARKER)) begin
					r = finish(r, pfbhex_pkg::ST_BAD_MARKER);
				end else begin
					r.st.hcnt = 3'd1;
				end
			end
			3'd1: begin
				r.st.seg_bin = (v == pfbhex_pkg::TYPE_BIN);
				if (v == pfbhex_pkg::TYPE_TEXT || v == pfbhex_pkg::TYPE_BIN) begin
					r.st.hcnt      = 3'd2;
					r.st.len_shift = 32'd0;
					if (eof) r = finish(r, pfbhex_pkg::ST_SHORT_HEADER);
				end else if (v == pfbhex_pkg::TYPE_END) begin
					r = finish(r, pfbhex_pkg::ST_END_SEGMENT);
				end else begin
					r = finish(r, pfbhex_pkg::ST_BAD_TYPE);
				end
			end
			[3'd2:3'd5]: begin
				lsh[k*8 +: 8]  = lsh[k*8 +: 8] | v;
				r.st.len_shift = lsh;
				r.st.hcnt      = r.st.hcnt + 3'd1;
				if (r.st.hcnt == 3'd6) begin
					r.st.remaining = (lsh > LEN_LIM) ? LEN_LIM[LENGTH_BITS-1:0]
						: lsh[LENGTH_BITS-1:0];
					r.st.phase = r.st.seg_bin ? pfbhex_pkg::PH_BINARY : pfbhex_pkg::PH_TEXT;
					r = after_payload(r, eof);
				end else if (eof) begin
					r = finish(r, pfbhex_pkg::ST_SHORT_HEADER);
				end
			end
			default: r = finish(r, pfbhex_pkg::ST_SHORT_HEADER);
		endcase
		return r;
	endfunction

	function automatic st_t clear_st();
		st_t s;
		s           = '0;
		s.phase     = pfbhex_pkg::PH_START;
		return s;
	endfunction

	always_comb begin
		nxt            = '0;
		nxt.st         = st_q;
		nxt.cmd.count  = '0;
		unique case (st_q.phase)
			pfbhex_pkg::PH_START: begin
				if (end_of_file) begin
					nxt = finish(nxt, pfbhex_pkg::ST_NO_HEADER);
				end else begin
					nxt.st.held  = in_byte;
					nxt.st.phase = pfbhex_pkg::PH_SECOND;
				end
			end
			pfbhex_pkg::PH_SECOND: begin
				if (st_q.held == pfbhex_pkg::CH_PERCENT && in_byte == pfbhex_pkg::CH_BANG) begin
					nxt = emit(nxt, pfbhex_pkg::CH_PERCENT, 1'b0, pfbhex_pkg::ST_END_SEGMENT);
					nxt = emit(nxt, pfbhex_pkg::CH_BANG, 1'b0, pfbhex_pkg::ST_END_SEGMENT);
					nxt.st.phase = pfbhex_pkg::PH_PASS;
					if (end_of_file) nxt = finish(nxt, pfbhex_pkg::ST_PASS_OK);
				end else begin
					nxt.st.phase = pfbhex_pkg::PH_HEADER;
					nxt.st.hcnt  = 3'd0;
					nxt = header_byte(nxt, st_q.held, 1'b0, mode_q);
					if (nxt.st.phase == pfbhex_pkg::PH_HEADER) begin
						nxt = header_byte(nxt, in_byte, end_of_file, mode_q);
					end
				end
			end
			pfbhex_pkg::PH_PASS: begin
				nxt = emit(nxt, in_byte, 1'b0, pfbhex_pkg::ST_END_SEGMENT);
				if (end_of_file) nxt = finish(nxt, pfbhex_pkg::ST_PASS_OK);
			end
			pfbhex_pkg::PH_HEADER: begin
				nxt = header_byte(nxt, in_byte, end_of_file, mode_q);
			end
			pfbhex_pkg::PH_TEXT: begin
				nxt = emit(nxt, (in_byte == pfbhex_pkg::CH_CR) ? pfbhex_pkg::CH_LF : in_byte,
					1'b0, pfbhex_pkg::ST_END_SEGMENT);
				nxt.st.remaining = nxt.st.remaining - LENGTH_BITS'(1);
				nxt = after_payload(nxt, end_of_file);
			end
			pfbhex_pkg::PH_BINARY: begin
				if (nxt.st.line_pos >= pfbhex_pkg::LINE_CHARS && nxt.st.line_pos != 8'd0) begin
					nxt = emit(nxt, pfbhex_pkg::CH_LF, 1'b0, pfbhex_pkg::ST_END_SEGMENT);
					nxt.st.line_pos = 8'd0;
				end
				nxt = emit(nxt, pfbhex_pkg::hex_char(in_byte[7:4]), 1'b0,
					pfbhex_pkg::ST_END_SEGMENT);
				nxt = emit(nxt, pfbhex_pkg::hex_char(in_byte[3:0]), 1'b0,
					pfbhex_pkg::ST_END_SEGMENT);
				nxt.st.line_pos  = nxt.st.line_pos + 8'd2;
				nxt.st.remaining = nxt.st.remaining - LENGTH_BITS'(1);
				nxt = after_payload(nxt, end_of_file);
			end
			default: begin
			end
		endcase
		if (end_of_file) nxt.st = clear_st();
	end

	always_comb begin
		in_ready = !q_full;
		accept   = in_valid && in_ready;
		q_push   = accept && (nxt.cmd.count != '0);
		q_cmd    = nxt.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= clear_st();
			mode_q <= 1'b0;
		end else begin
			if (accept) st_q <= nxt.st;
			if (cfg_wen) mode_q <= cfg_wdata;
		end
	end

endmodule

// ===== rtl/pfbhex_queue.sv =====
// ----------------------------------------------------------------------------
// pfbhex_queue
// Short command queue between the parser and the output serializer.
// ----------------------------------------------------------------------------
module pfbhex_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pfbhex_pkg::cmd_t push_cmd,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output pfbhex_pkg::cmd_t head_cmd
);

	pfbhex_pkg::cmd_t                  mem_q [pfbhex_pkg::QUEUE_DEPTH];
	logic [pfbhex_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pfbhex_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pfbhex_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == pfbhex_pkg::QCNT_W'(pfbhex_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + pfbhex_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + pfbhex_pkg::QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + pfbhex_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - pfbhex_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pfbhex_back.sv =====
// ----------------------------------------------------------------------------
// pfbhex_back
// Serializes queued commands into single result items through an output
// register.
// ----------------------------------------------------------------------------
module pfbhex_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pfbhex_pkg::cmd_t head_cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output pfbhex_pkg::res_t out_res,
	output logic             out_last
);

	logic [pfbhex_pkg::RES_CNT_W-1:0] idx_q;
	logic                             valid_q;
	pfbhex_pkg::res_t                 res_q;
	logic                             last_q;
	logic                             load;
	logic                             is_last;

	always_comb begin
		load    = head_valid && (!valid_q || out_ready);
		is_last = (idx_q == head_cmd.count - 3'd1);
		pop     = load && is_last;
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head_cmd.items[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (!valid_q || out_ready) valid_q <= head_valid;
			if (load) idx_q <= is_last ? '0 : idx_q + 3'd1;
		end
	end

endmodule

// ===== verif/pfb_segments_to_hex_text_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pfb_segments_to_hex_text_unit_tb
// Self-checking bench for the binary-font to hex-text converter. Byte files
// are streamed in, and each output transfer is checked field by field
// against a behavioral copy of the converter: passthrough files, text and
// binary segments, header faults, truncation and both header modes. Both
// stream sides insert random gaps, and the output side is held off for a
// long stretch once so that the block stalls its input.
// ----------------------------------------------------------------------------
module pfb_segments_to_hex_text_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    IDLE_LIMIT    = 3000;
	localparam int    DRAIN_SETTLE  = 40;
	localparam int    PHASE_BYTES   = 30;
	localparam string HEX_ALPHABET  = "0123456789ABCDEF";

	typedef struct packed {
		pfbhex_pkg::res_t body;
		logic             last;
	} text_out_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// converter state mirrored for prediction
	logic               hdr_inverted;
	pfbhex_pkg::phase_t conv_phase;
	logic [7:0]         first_byte;
	logic [2:0]         hdr_cnt;
	logic [7:0]         seg_type;
	logic [31:0]        len_acc;
	logic [31:0]        remaining;
	logic [7:0]         line_pos;

	text_out_t   step_text[$];
	text_out_t   expected_text[$];
	logic [7:0]  file_buf[$];

	int tx_gap_max     = 18;
	int rx_gap_max     = 18;
	int rx_wait        = 0;
	int rx_hold_cycles = 0;
	int idle_cycles    = 0;
	int error_count    = 0;
	int bytes_sent     = 0;

	pfb_segments_to_hex_text_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int draw_gap(input int max_gap);
		if (max_gap == 0 || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, max_gap);
	endfunction

	// ---------------- converter prediction ----------------

	function automatic void clear_conv();
		conv_phase = pfbhex_pkg::PH_START;
		first_byte = 8'd0;
		hdr_cnt    = 3'd0;
		seg_type   = 8'd0;
		len_acc    = 32'd0;
		remaining  = 32'd0;
		line_pos   = 8'd0;
	endfunction

	function automatic void put_text(input logic [7:0] ch, input logic stat,
		input logic [2:0] code);
		text_out_t t;
		if (step_text.size() >= pfbhex_pkg::MAX_RES) begin
			return;
		end
		t.body.out_byte  = ch;
		t.body.is_status = stat;
		t.body.status    = code;
		t.last           = 1'b0;
		step_text.push_back(t);
	endfunction

	function automatic void close_file(input logic [2:0] code);
		put_text(8'd0, 1'b1, code);
		conv_phase = pfbhex_pkg::PH_DONE;
	endfunction

	function automatic void end_segment();
		if (seg_type == pfbhex_pkg::TYPE_BIN && line_pos > 8'd0) begin
			put_text(pfbhex_pkg::CH_LF, 1'b0, 3'd0);
			line_pos = 8'd0;
		end
		conv_phase = pfbhex_pkg::PH_HEADER;
		hdr_cnt    = 3'd0;
	endfunction

	function automatic void payload_done(input logic eof);
		if (remaining == 32'd0) begin
			end_segment();
			if (eof) begin
				close_file(pfbhex_pkg::ST_NO_HEADER);
			end
		end else if (eof) begin
			end_segment();
			close_file(pfbhex_pkg::ST_TRUNCATED);
		end
	endfunction

	function automatic void take_header(input logic [7:0] b, input logic eof);
		logic [7:0] v;
		v = hdr_inverted ? ~b : b;
		case (hdr_cnt) inside
			3'd0: begin
				if (eof) begin
					close_file(pfbhex_pkg::ST_NO_HEADER);
				end else if (b != (hdr_inverted ? pfbhex_pkg::MARKER_INV
					: pfbhex_pkg::MARKER)) begin
					close_file(pfbhex_pkg::ST_BAD_MARKER);
				end else begin
					hdr_cnt = 3'd1;
				end
			end
			3'd1: begin
				seg_type = v;
				if (v == pfbhex_pkg::TYPE_TEXT || v == pfbhex_pkg::TYPE_BIN) begin
					hdr_cnt = 3'd2;
					len_acc = 32'd0;
					if (eof) begin
						close_file(pfbhex_pkg::ST_SHORT_HEADER);
					end
				end else if (v == pfbhex_pkg::TYPE_END) begin
					close_file(pfbhex_pkg::ST_END_SEGMENT);
				end else begin
					close_file(pfbhex_pkg::ST_BAD_TYPE);
				end
			end
			[3'd2:3'd5]: begin
				len_acc = len_acc | ({24'd0, v} << (8 * (hdr_cnt - 3'd2)));
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt == 3'd6) begin
					remaining  = len_acc;
					conv_phase = (seg_type == pfbhex_pkg::TYPE_TEXT) ? pfbhex_pkg::PH_TEXT
						: pfbhex_pkg::PH_BINARY;
					payload_done(eof);
				end else if (eof) begin
					close_file(pfbhex_pkg::ST_SHORT_HEADER);
				end
			end
			default: begin
				close_file(pfbhex_pkg::ST_SHORT_HEADER);
			end
		endcase
	endfunction

	function automatic void convert_byte(input logic [7:0] b, input logic eof);
		step_text.delete();
		case (conv_phase)
			pfbhex_pkg::PH_START: begin
				if (eof) begin
					close_file(pfbhex_pkg::ST_NO_HEADER);
				end else begin
					first_byte = b;
					conv_phase = pfbhex_pkg::PH_SECOND;
				end
			end
			pfbhex_pkg::PH_SECOND: begin
				if (first_byte == pfbhex_pkg::CH_PERCENT && b == pfbhex_pkg::CH_BANG) begin
					put_text(pfbhex_pkg::CH_PERCENT, 1'b0, 3'd0);
					put_text(pfbhex_pkg::CH_BANG, 1'b0, 3'd0);
					conv_phase = pfbhex_pkg::PH_PASS;
					if (eof) begin
						close_file(pfbhex_pkg::ST_PASS_OK);
					end
				end else begin
					conv_phase = pfbhex_pkg::PH_HEADER;
					hdr_cnt    = 3'd0;
					take_header(first_byte, 1'b0);
					if (conv_phase == pfbhex_pkg::PH_HEADER) begin
						take_header(b, eof);
					end
				end
			end
			pfbhex_pkg::PH_PASS: begin
				put_text(b, 1'b0, 3'd0);
				if (eof) begin
					close_file(pfbhex_pkg::ST_PASS_OK);
				end
			end
			pfbhex_pkg::PH_HEADER: begin
				take_header(b, eof);
			end
			pfbhex_pkg::PH_TEXT: begin
				put_text((b == pfbhex_pkg::CH_CR) ? pfbhex_pkg::CH_LF : b, 1'b0, 3'd0);
				remaining = remaining - 32'd1;
				payload_done(eof);
			end
			pfbhex_pkg::PH_BINARY: begin
				if (line_pos >= pfbhex_pkg::LINE_CHARS && line_pos > 8'd0) begin
					put_text(pfbhex_pkg::CH_LF, 1'b0, 3'd0);
					line_pos = 8'd0;
				end
				put_text(HEX_ALPHABET[b[7:4]], 1'b0, 3'd0);
				put_text(HEX_ALPHABET[b[3:0]], 1'b0, 3'd0);
				line_pos  = line_pos + 8'd2;
				remaining = remaining - 32'd1;
				payload_done(eof);
			end
			default: begin
			end
		endcase
		if (eof) begin
			clear_conv();
		end
		if (step_text.size() > 0) begin
			step_text[step_text.size() - 1].last = 1'b1;
		end
		foreach (step_text[i]) begin
			expected_text.push_back(step_text[i]);
		end
	endfunction

	// ---------------- output side ----------------

	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		text_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait = draw_gap(rx_gap_max);
			if (expected_text.size() == 0) begin
				if (error_count < 10) begin
					$display("unexpected transfer: data=%h user=%b last=%b",
						m_tdata, m_tuser, m_tlast);
				end
				error_count++;
			end else begin
				want = expected_text.pop_front();
				if (m_tdata[7:0] !== want.body.out_byte || m_tdata[10:8] !== want.body.status
					|| m_tdata[15:11] !== 5'd0 || m_tuser !== want.body.is_status
					|| m_tlast !== want.last) begin
					if (error_count < 10) begin
						$display("mismatch: exp byte=%h status=%0d is_status=%b last=%b",
							want.body.out_byte, want.body.status, want.body.is_status,
							want.last);
						$display("          got byte=%h status=%0d is_status=%b last=%b pad=%h",
							m_tdata[7:0], m_tdata[10:8], m_tuser, m_tlast, m_tdata[15:11]);
					end
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------- input side ----------------

	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		gap = draw_gap(tx_gap_max);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eof;
		do begin
			@(posedge clk);
		end while (!(s_tvalid && s_tready));
		convert_byte(b, eof);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_buf.size(); i++) begin
			send_byte(file_buf[i], i == file_buf.size() - 1);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_header_mode(input logic mode);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		hdr_inverted = mode;
	endtask

	// ---------------- file building ----------------

	function automatic logic [7:0] marker_byte();
		return hdr_inverted ? pfbhex_pkg::MARKER_INV : pfbhex_pkg::MARKER;
	endfunction

	function automatic logic [7:0] hdr_enc(input logic [7:0] v);
		return hdr_inverted ? ~v : v;
	endfunction

	function automatic void add_header(input logic [7:0] typ, input logic [31:0] len,
		input int len_bytes);
		file_buf.push_back(marker_byte());
		file_buf.push_back(hdr_enc(typ));
		for (int i = 0; i < len_bytes; i++) begin
			file_buf.push_back(hdr_enc(len[8*i +: 8]));
		end
	endfunction

	function automatic void add_payload(input logic [7:0] typ, input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (typ == pfbhex_pkg::TYPE_TEXT && $urandom_range(0, 3) == 0) begin
				b = pfbhex_pkg::CH_CR;
			end
			file_buf.push_back(b);
		end
	endfunction

	function automatic void build_random_file();
		int          kind;
		int          nseg;
		int          ending;
		int          len;
		logic [7:0]  typ;
		logic [7:0]  b;
		logic [31:0] decl;
		file_buf.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) file_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			file_buf.push_back(pfbhex_pkg::CH_PERCENT);
			file_buf.push_back(pfbhex_pkg::CH_BANG);
			add_payload(pfbhex_pkg::TYPE_TEXT, $urandom_range(0, 8));
		end else begin
			nseg   = $urandom_range(1, 3);
			ending = $urandom_range(0, 6);
			for (int i = 0; i < nseg; i++) begin
				typ  = $urandom_range(0, 1) ? pfbhex_pkg::TYPE_BIN : pfbhex_pkg::TYPE_TEXT;
				len  = ($urandom_range(0, 3) == 0) ? $urandom_range(36, 45)
					: $urandom_range(0, 10);
				decl = len;
				if (i == nseg - 1 && ending == 2) begin
					decl = $urandom_range(0, 1) ? len + $urandom_range(1, 5)
						: ($urandom() | 32'h0100_0000);
				end
				add_header(typ, decl, 4);
				add_payload(typ, len);
			end
			case (ending)
				0: begin
					add_header(pfbhex_pkg::TYPE_END, 32'd0, 0);
					repeat ($urandom_range(0, 2)) file_buf.push_back(8'($urandom_range(0, 255)));
				end
				3: begin
					add_header($urandom_range(0, 1) ? pfbhex_pkg::TYPE_BIN
						: pfbhex_pkg::TYPE_TEXT, $urandom(), $urandom_range(0, 3));
				end
				4: begin
					do begin
						b = 8'($urandom_range(0, 255));
					end while (b == marker_byte());
					file_buf.push_back(b);
					repeat ($urandom_range(0, 2)) file_buf.push_back(8'($urandom_range(0, 255)));
				end
				5: begin
					do begin
						typ = 8'($urandom_range(0, 255));
					end while (typ inside {pfbhex_pkg::TYPE_TEXT, pfbhex_pkg::TYPE_BIN,
						pfbhex_pkg::TYPE_END});
					add_header(typ, 32'd0, 0);
				end
				6: begin
					file_buf.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
				end
			endcase
		end
	endfunction

	// ---------------- tests ----------------

	task automatic test_one_byte_file();
		file_buf = '{8'h25};
		send_file();
	endtask

	task automatic test_passthrough();
		file_buf = '{pfbhex_pkg::CH_PERCENT, pfbhex_pkg::CH_BANG, pfbhex_pkg::CH_CR, 8'hFF};
		send_file();
	endtask

	task automatic test_zero_length_then_eof();
		file_buf = '{pfbhex_pkg::MARKER, pfbhex_pkg::TYPE_BIN, 8'h00, 8'h00, 8'h00, 8'h00};
		send_file();
	endtask

	task automatic test_bad_marker();
		file_buf = '{8'h7F, 8'h02, 8'h55};
		send_file();
	endtask

	task automatic test_unknown_type();
		file_buf = '{pfbhex_pkg::MARKER, 8'h07};
		send_file();
	endtask

	task automatic test_short_header();
		file_buf = '{pfbhex_pkg::MARKER, pfbhex_pkg::TYPE_TEXT, 8'h05};
		send_file();
	endtask

	task automatic test_truncated_payload();
		file_buf = '{pfbhex_pkg::MARKER, pfbhex_pkg::TYPE_BIN, 8'h05, 8'h00, 8'h00, 8'h00,
			8'hAB};
		send_file();
	endtask

	task automatic test_inverted_header();
		drain_results();
		write_header_mode(1'b1);
		file_buf.delete();
		add_header(pfbhex_pkg::TYPE_END, 32'd0, 0);
		send_file();
		drain_results();
	endtask

	task automatic test_output_backpressure();
		file_buf.delete();
		add_header(pfbhex_pkg::TYPE_BIN, 32'd44, 4);
		add_payload(pfbhex_pkg::TYPE_BIN, 44);
		tx_gap_max     = 0;
		rx_hold_cycles = 150;
		send_file();
		drain_results();
		tx_gap_max = 18;
	endtask

	task automatic test_random_files();
		int start;
		for (int p = 0; p < 6; p++) begin
			drain_results();
			case (p)
				0: write_header_mode(1'b0);
				1: write_header_mode(1'b1);
				2: write_header_mode(1'b0);
				3: write_header_mode(1'b1);
				default: write_header_mode(1'($urandom_range(0, 1)));
			endcase
			tx_gap_max = (p == 0 || p == 2) ? 0 : 18;
			rx_gap_max = (p == 0 || p == 3) ? 0 : 18;
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				build_random_file();
				send_file();
			end
		end
		tx_gap_max = 18;
		rx_gap_max = 18;
	endtask

	initial begin
		hdr_inverted = 1'b0;
		clear_conv();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_header_mode(1'b0);

		test_one_byte_file();
		test_passthrough();
		test_zero_length_then_eof();
		test_bad_marker();
		test_unknown_type();
		test_short_header();
		test_truncated_payload();
		test_inverted_header();
		test_output_backpressure();
		test_random_files();

		drain_results();
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
